@@ src/abelian_pattern_occurrence_check_core_assert.svh @@
// Assertion macros for the abelian pattern occurrence check core.
`ifndef ABELIAN_PATTERN_OCCURRENCE_CHECK_CORE_ASSERT_SVH
`define ABELIAN_PATTERN_OCCURRENCE_CHECK_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition that holds at every clock edge out of reset.
`define APOC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Condition that holds in the cycle after the antecedent.
`define APOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define APOC_ASSERT(lbl, expr)
`define APOC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/apoc_pkg.sv @@
// Shared constants and types of the abelian pattern occurrence check core.
`default_nettype none
package apoc_pkg;
  localparam int WORD_DEPTH    = 64;
  localparam int PATTERN_DEPTH = 16;
  localparam int WAW = $clog2(WORD_DEPTH);
  localparam int WCW = WAW + 1;
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int PDW = WCW + 1;
  // a compared pair needs two pattern letters, so a block is at most half the word
  localparam int TAKEN_DEPTH = WORD_DEPTH / 2;
  localparam int TAW = (TAKEN_DEPTH > 1) ? $clog2(TAKEN_DEPTH) : 1;

  localparam logic MODE_WORD    = 1'b0;
  localparam logic MODE_PATTERN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DCHK,
    ST_SCHK,
    ST_JCHK,
    ST_KRD,
    ST_KCMP,
    ST_ICHK,
    ST_MRD,
    ST_MCMP,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

@@ src/abelian_pattern_occurrence_check_core.sv @@
// Top level of the abelian pattern occurrence check core.
//
// Input stream: one character per request. in_tuser selects pattern (1) or
// word (0), in_tlast marks the last character of a pattern or word. A
// pattern is kept until the next one is loaded. The last character of a
// word starts a search, and the block then sends one request on the output
// stream: tdata[0] = found, tdata[1] = overflow (a store dropped characters).
// Characters load at one per cycle while the block is idle. The search is a
// sequencer over block lengths, start positions, pattern pairs and block
// characters; each character comparison reads both word blocks through the
// two read ports of the word memory, in a read state and then a compare
// state. No input is taken during a search.
// Reset empties both stores and closes any open load; no clearing pass.
// When the receiver stalls, the result waits in the output register; the
// block keeps loading characters and only holds a later finished search.
`default_nettype none
`include "abelian_pattern_occurrence_check_core_assert.svh"
module abelian_pattern_occurrence_check_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic       in_tuser,   // [0] mode
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] found, [1] overflow, [7:2] zero
);
  localparam int WAW = apoc_pkg::WAW;
  localparam int WCW = apoc_pkg::WCW;
  localparam int PAW = apoc_pkg::PAW;
  localparam int PCW = apoc_pkg::PCW;
  localparam int PDW = apoc_pkg::PDW;
  localparam int TAW = apoc_pkg::TAW;

  logic [7:0] word_mem [apoc_pkg::WORD_DEPTH];
  logic [7:0] pat_mem  [apoc_pkg::PATTERN_DEPTH];
  logic [7:0] wqa_r, wqb_r, pqj_r, pqk_r;

  apoc_pkg::state_t state_r, state_nxt;
  logic [WCW-1:0] wcnt_r, wcnt_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic           wopen_r, wopen_nxt, popen_r, popen_nxt;
  logic           wovf_r, wovf_nxt, povf_r, povf_nxt;
  logic [WCW-1:0] d_r, d_nxt, s_r, s_nxt, aj_r, aj_nxt, bk_r, bk_nxt;
  logic [WCW-1:0] i_r, i_nxt, jj_r, jj_nxt;
  logic [PDW-1:0] pd_r, pd_nxt;
  logic [PCW-1:0] j_r, j_nxt, k_r, k_nxt;
  logic [apoc_pkg::TAKEN_DEPTH-1:0] taken_r, taken_nxt;
  logic           found_r, found_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic [1:0]     odata_r, odata_nxt;

  logic           in_acc;
  logic           word_end;
  logic           w_we, p_we;
  logic [WAW-1:0] w_wa;
  logic [PAW-1:0] p_wa;
  logic [WCW-1:0] wra_sum, wrb_sum;
  logic [WCW-1:0] wcnt_eff;
  logic [PCW-1:0] pcnt_eff;

  assign in_tready  = (state_r == apoc_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign word_end   = in_acc && (in_tuser == apoc_pkg::MODE_WORD) && in_tlast;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, odata_r};
  assign wra_sum    = aj_r + i_r;
  assign wrb_sum    = bk_r + jj_r;
  assign wcnt_eff   = wopen_r ? wcnt_r : '0;
  assign pcnt_eff   = popen_r ? pcnt_r : '0;

  always_ff @(posedge clk) begin
    if (w_we) begin
      word_mem[w_wa] <= in_tdata;
    end
    if (p_we) begin
      pat_mem[p_wa] <= in_tdata;
    end
    wqa_r <= word_mem[wra_sum[WAW-1:0]];
    wqb_r <= word_mem[wrb_sum[WAW-1:0]];
    pqj_r <= pat_mem[j_r[PAW-1:0]];
    pqk_r <= pat_mem[k_r[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= apoc_pkg::ST_IDLE;
      wcnt_r   <= '0;
      pcnt_r   <= '0;
      wopen_r  <= 1'b0;
      popen_r  <= 1'b0;
      wovf_r   <= 1'b0;
      povf_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wcnt_r   <= wcnt_nxt;
      pcnt_r   <= pcnt_nxt;
      wopen_r  <= wopen_nxt;
      popen_r  <= popen_nxt;
      wovf_r   <= wovf_nxt;
      povf_r   <= povf_nxt;
      ovalid_r <= ovalid_nxt;
    end
    d_r     <= d_nxt;
    pd_r    <= pd_nxt;
    s_r     <= s_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    aj_r    <= aj_nxt;
    bk_r    <= bk_nxt;
    i_r     <= i_nxt;
    jj_r    <= jj_nxt;
    taken_r <= taken_nxt;
    found_r <= found_nxt;
    odata_r <= odata_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    wcnt_nxt   = wcnt_r;
    pcnt_nxt   = pcnt_r;
    wopen_nxt  = wopen_r;
    popen_nxt  = popen_r;
    wovf_nxt   = wovf_r;
    povf_nxt   = povf_r;
    d_nxt      = d_r;
    pd_nxt     = pd_r;
    s_nxt      = s_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    aj_nxt     = aj_r;
    bk_nxt     = bk_r;
    i_nxt      = i_r;
    jj_nxt     = jj_r;
    taken_nxt  = taken_r;
    found_nxt  = found_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    w_we       = 1'b0;
    p_we       = 1'b0;
    w_wa       = wcnt_eff[WAW-1:0];
    p_wa       = pcnt_eff[PAW-1:0];
    case (state_r)
      apoc_pkg::ST_IDLE: begin
        if (in_acc && in_tuser == apoc_pkg::MODE_PATTERN) begin
          povf_nxt = popen_r ? povf_r : 1'b0;
          pcnt_nxt = pcnt_eff;
          if (pcnt_eff < PCW'(apoc_pkg::PATTERN_DEPTH)) begin
            p_we     = 1'b1;
            pcnt_nxt = pcnt_eff + PCW'(1);
          end else begin
            povf_nxt = 1'b1;
          end
          popen_nxt = !in_tlast;
        end else if (in_acc) begin
          wovf_nxt = wopen_r ? wovf_r : 1'b0;
          wcnt_nxt = wcnt_eff;
          if (wcnt_eff < WCW'(apoc_pkg::WORD_DEPTH)) begin
            w_we     = 1'b1;
            wcnt_nxt = wcnt_eff + WCW'(1);
          end else begin
            wovf_nxt = 1'b1;
          end
          wopen_nxt = !in_tlast;
          if (in_tlast) begin
            // start the search with block length one
            d_nxt     = WCW'(1);
            pd_nxt    = PDW'(pcnt_r);
            found_nxt = 1'b1;
            state_nxt = (pcnt_r == '0) ? apoc_pkg::ST_DONE : apoc_pkg::ST_DCHK;
          end
        end
      end
      apoc_pkg::ST_DCHK: begin
        if (pd_r > PDW'(wcnt_r)) begin
          found_nxt = 1'b0;
          state_nxt = apoc_pkg::ST_DONE;
        end else begin
          s_nxt     = '0;
          state_nxt = apoc_pkg::ST_SCHK;
        end
      end
      apoc_pkg::ST_SCHK: begin
        if ((PDW'(s_r) + pd_r) > PDW'(wcnt_r)) begin
          d_nxt     = d_r + WCW'(1);
          pd_nxt    = pd_r + PDW'(pcnt_r);
          state_nxt = apoc_pkg::ST_DCHK;
        end else begin
          j_nxt     = '0;
          aj_nxt    = s_r;
          state_nxt = apoc_pkg::ST_JCHK;
        end
      end
      apoc_pkg::ST_JCHK: begin
        if (j_r >= pcnt_r) begin
          found_nxt = 1'b1;
          state_nxt = apoc_pkg::ST_DONE;
        end else begin
          k_nxt     = j_r + PCW'(1);
          bk_nxt    = aj_r + d_r;
          state_nxt = apoc_pkg::ST_KRD;
        end
      end
      apoc_pkg::ST_KRD: begin
        if (k_r >= pcnt_r) begin
          j_nxt     = j_r + PCW'(1);
          aj_nxt    = aj_r + d_r;
          state_nxt = apoc_pkg::ST_JCHK;
        end else begin
          state_nxt = apoc_pkg::ST_KCMP;
        end
      end
      apoc_pkg::ST_KCMP: begin
        if (pqj_r == pqk_r) begin
          taken_nxt = '0;
          i_nxt     = '0;
          state_nxt = apoc_pkg::ST_ICHK;
        end else begin
          k_nxt     = k_r + PCW'(1);
          bk_nxt    = bk_r + d_r;
          state_nxt = apoc_pkg::ST_KRD;
        end
      end
      apoc_pkg::ST_ICHK: begin
        if (i_r >= d_r) begin
          // blocks are permutations: move to the next pair
          k_nxt     = k_r + PCW'(1);
          bk_nxt    = bk_r + d_r;
          state_nxt = apoc_pkg::ST_KRD;
        end else begin
          jj_nxt    = '0;
          state_nxt = apoc_pkg::ST_MRD;
        end
      end
      apoc_pkg::ST_MRD: begin
        if (jj_r >= d_r) begin
          // no partner for this character: drop this start position
          s_nxt     = s_r + WCW'(1);
          state_nxt = apoc_pkg::ST_SCHK;
        end else begin
          state_nxt = apoc_pkg::ST_MCMP;
        end
      end
      apoc_pkg::ST_MCMP: begin
        if (!taken_r[jj_r[TAW-1:0]] && wqa_r == wqb_r) begin
          taken_nxt[jj_r[TAW-1:0]] = 1'b1;
          i_nxt     = i_r + WCW'(1);
          state_nxt = apoc_pkg::ST_ICHK;
        end else begin
          jj_nxt    = jj_r + WCW'(1);
          state_nxt = apoc_pkg::ST_MRD;
        end
      end
      apoc_pkg::ST_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {wovf_r | povf_r, found_r};
          state_nxt  = apoc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = apoc_pkg::ST_IDLE;
      end
    endcase
  end

  `APOC_ASSERT(a_wcnt_bound, wcnt_r <= WCW'(apoc_pkg::WORD_DEPTH))
  `APOC_ASSERT(a_pcnt_bound, pcnt_r <= PCW'(apoc_pkg::PATTERN_DEPTH))
  `APOC_ASSERT(a_jj_bound, (state_r != apoc_pkg::ST_MCMP) || (jj_r < d_r))
  `APOC_ASSERT_NEXT(a_search_starts, word_end, state_r != apoc_pkg::ST_IDLE)
endmodule
`default_nettype wire
